// ===== hdl/pff_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_pkg: shared types and constants for the PCM frame FIFO
// Action codes, register indexes, reset values and controller/datapath buses.
// ----------------------------------------------------------------------------
package pff_pkg;

	localparam int RING_DEPTH_DFLT = 8192;
	localparam int GAIN_FRAC_DFLT  = 12;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int BYTES_W  = 32;
	localparam int URUN_W   = 32;
	localparam int FILL_W   = 14;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

	// request actions
	localparam logic [1:0] ACT_PUSH    = 2'd0;
	localparam logic [1:0] ACT_PULL    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MONO   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STREAM = 2'd2;

	typedef struct packed {
		logic push;
		logic pull;
		logic restart;
		logic mul;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic out_valid;
	} dp_stat_t;

endpackage

// ===== hdl/pff_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_ctrl: request sequencer
// Takes requests, issues push/pull/restart commands and steps a pull through
// the multiply and saturate stages into the output register.
// ----------------------------------------------------------------------------
module pff_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	output pff_pkg::ctrl_cmd_t   cmd,
	input  pff_pkg::dp_stat_t    stat
);
	import pff_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MULT = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       take;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd.push    = take && (action == ACT_PUSH);
		cmd.pull    = take && (action == ACT_PULL);
		cmd.restart = take && (action == ACT_RESTART);
		cmd.mul     = (state_q == ST_MULT);
		cmd.load    = (state_q == ST_SAT) && stat.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.pull) state_d = ST_MULT;
			end
			ST_MULT: state_d = ST_SAT;
			ST_SAT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_pull_to_mult: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pull |=> state_q == ST_MULT)
		else $error("pull did not enter multiply stage");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MULT |=> state_q == ST_SAT && !in_ready)
		else $error("multiply stage not followed by saturate stage");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> stat.out_valid && state_q == ST_IDLE)
		else $error("result load lost");
`endif

endmodule

// ===== hdl/pff_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_datapath: byte assembly, frame ring, gain scaling and result register
// Holds the config registers, stream counters, the stereo ring memory and
// the two-stage multiply / truncate-saturate path.
// ----------------------------------------------------------------------------
module pff_datapath #(
	parameter int RING_DEPTH     = pff_pkg::RING_DEPTH_DFLT,
	parameter int GAIN_FRAC_BITS = pff_pkg::GAIN_FRAC_DFLT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pff_pkg::ctrl_cmd_t              cmd,
	output pff_pkg::dp_stat_t               stat,
	input  logic [7:0]                      data_byte,
	input  logic                            cfg_we,
	input  logic [pff_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pff_pkg::CFG_W-1:0]       cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [pff_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [pff_pkg::SAMPLE_W-1:0] right_sample,
	output logic                            underrun,
	output logic [pff_pkg::FILL_W-1:0]      fill_level,
	output logic                            finished,
	output logic [pff_pkg::URUN_W-1:0]      underrun_total
);
	import pff_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
	localparam logic signed [33:0] RND = (34'sd1 <<< GAIN_FRAC_BITS) - 34'sd1;

	// config registers
	logic                 mono_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [BYTES_W-1:0]   stream_bytes_q;

	// stream state
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [23:0]          partial_q;
	logic [1:0]           phase_q;
	logic [BYTES_W-1:0]   bytes_taken_q;
	logic [URUN_W-1:0]    urun_q;

	logic [SAMPLE_W-1:0]  left_mem  [RING_DEPTH];
	logic [SAMPLE_W-1:0]  right_mem [RING_DEPTH];

	// pull pipeline
	logic [SAMPLE_W-1:0]  left_s1, right_s1;
	logic                 under_s1, fin_s1;
	logic [FILL_W-1:0]    fill_s1;
	logic [URUN_W-1:0]    total_s1;
	logic signed [32:0]   prod_l_s2, prod_r_s2;

	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  left_q, right_q;
	logic                 under_q, fin_q;
	logic [FILL_W-1:0]    fill_q;
	logic [URUN_W-1:0]    total_q;

	logic                 byte_ok, frame_done, ring_full, wr_en, under_now;
	logic [SAMPLE_W-1:0]  mono_smp, left_in, right_in;
	logic [CNT_W-1:0]     cnt_pull;
	logic [CNT_W+FILL_W-1:0] fill_ext;
	logic [URUN_W-1:0]    urun_next;
	logic [SAMPLE_W-1:0]  left_eff, right_eff;

	function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [32:0] p);
		logic signed [33:0] s;
		logic signed [33:0] q;
		s = $signed({p[32], p}) + (p[32] ? RND : 34'sd0);
		q = s >>> GAIN_FRAC_BITS;
		if (q > 34'sd32767) return 16'h7fff;
		else if (q < -34'sd32768) return 16'h8000;
		else return q[15:0];
	endfunction

	// byte assembly
	assign byte_ok    = bytes_taken_q < stream_bytes_q;
	assign frame_done = mono_q ? (phase_q != 2'd0) : (phase_q == 2'd3);
	assign mono_smp   = {data_byte, partial_q[7:0]};
	assign left_in    = mono_q ? mono_smp : partial_q[15:0];
	assign right_in   = mono_q ? mono_smp : {data_byte, partial_q[23:16]};
	assign ring_full  = (cnt_q == CNT_FULL);
	assign wr_en      = cmd.push && byte_ok && frame_done && !ring_full;

	// pull bookkeeping, values after this pull
	assign under_now = (cnt_q == '0);
	assign cnt_pull  = under_now ? cnt_q : cnt_q - CNT_W'(1);
	assign fill_ext  = {{FILL_W{1'b0}}, cnt_pull};
	assign urun_next = (under_now && urun_q != '1) ? urun_q + URUN_W'(1) : urun_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q         <= 1'b0;
			gain_q         <= GAIN_RESET;
			stream_bytes_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MONO:   mono_q         <= cfg_data[0];
				REG_GAIN:   gain_q         <= cfg_data[GAIN_W-1:0];
				REG_STREAM: stream_bytes_q <= cfg_data[BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			cnt_q         <= '0;
			partial_q     <= '0;
			phase_q       <= '0;
			bytes_taken_q <= '0;
			urun_q        <= '0;
		end else if (cmd.restart) begin
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			cnt_q         <= '0;
			partial_q     <= '0;
			phase_q       <= '0;
			bytes_taken_q <= '0;
			urun_q        <= '0;
		end else if (cmd.push && byte_ok) begin
			bytes_taken_q <= bytes_taken_q + BYTES_W'(1);
			if (frame_done) begin
				partial_q <= '0;
				phase_q   <= '0;
				if (wr_en) begin
					wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
					cnt_q    <= cnt_q + CNT_W'(1);
				end
			end else begin
				phase_q <= phase_q + 2'd1;
				unique case (phase_q)
					2'd0: partial_q[7:0]   <= data_byte;
					2'd1: partial_q[15:8]  <= data_byte;
					2'd2: partial_q[23:16] <= data_byte;
					default: ;
				endcase
			end
		end else if (cmd.pull) begin
			urun_q <= urun_next;
			cnt_q  <= cnt_pull;
			if (!under_now) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
		end
	end

	// ring memory, one write and one registered read port per channel
	always_ff @(posedge clk) begin
		if (wr_en) begin
			left_mem[wr_ptr_q]  <= left_in;
			right_mem[wr_ptr_q] <= right_in;
		end
		if (cmd.pull) begin
			left_s1  <= left_mem[rd_ptr_q];
			right_s1 <= right_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pull) begin
			under_s1 <= under_now;
			fill_s1  <= fill_ext[FILL_W-1:0];
			fin_s1   <= (bytes_taken_q >= stream_bytes_q) && (cnt_pull == '0);
			total_s1 <= urun_next;
		end
	end

	// empty ring gives zeros
	assign left_eff  = under_s1 ? '0 : left_s1;
	assign right_eff = under_s1 ? '0 : right_s1;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_l_s2 <= $signed(left_eff) * $signed({1'b0, gain_q});
			prod_r_s2 <= $signed(right_eff) * $signed({1'b0, gain_q});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_q  <= sat16(prod_l_s2);
			right_q <= sat16(prod_r_s2);
			under_q <= under_s1;
			fill_q  <= fill_s1;
			fin_q   <= fin_s1;
			total_q <= total_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.out_valid = out_valid_q;

	assign out_valid      = out_valid_q;
	assign left_sample    = left_q;
	assign right_sample   = right_q;
	assign underrun       = under_q;
	assign fill_level     = fill_q;
	assign finished       = fin_q;
	assign underrun_total = total_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("frame count above ring depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("empty ring with unequal pointers");
	a_under_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && under_q |-> left_q == '0 && right_q == '0)
		else $error("underrun result carries nonzero samples");
`endif

endmodule

// ===== hdl/pcm_frame_fifo_with_gain_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_frame_fifo_with_gain_unit: PCM byte to frame ring FIFO with output gain
//
//   channel  signals                               carries
//   in       in_valid / in_ready                   action, data_byte
//   out      out_valid / out_ready                 scaled frame and status
//   cfg      cfg_we, cfg_index, cfg_data           mono_mode, gain_q12, stream_bytes
//
// Push, restart and unused requests leave the sequencer idle.
// A pull steps through ring read, multiply and truncate/saturate into the
// output register; the ring read and the multiply result are registered.
// A pull stalls in its last stage while a held result is not taken, and no
// request is taken meanwhile. Reset clears pointers, counters, byte assembly
// state, config registers and valid flag but not ring memory; no clearing pass runs.
// ----------------------------------------------------------------------------
module pcm_frame_fifo_with_gain_unit #(
	parameter int RING_DEPTH     = pff_pkg::RING_DEPTH_DFLT,
	parameter int GAIN_FRAC_BITS = pff_pkg::GAIN_FRAC_DFLT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           action,
	input  logic [7:0]                           data_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pff_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [pff_pkg::SAMPLE_W-1:0] right_sample,
	output logic                                 underrun,
	output logic [pff_pkg::FILL_W-1:0]           fill_level,
	output logic                                 finished,
	output logic [pff_pkg::URUN_W-1:0]           underrun_total,
	input  logic                                 cfg_we,
	input  logic [pff_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pff_pkg::CFG_W-1:0]            cfg_data
);
	import pff_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	pff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.cmd      (cmd),
		.stat     (stat)
	);

	pff_datapath #(
		.RING_DEPTH     (RING_DEPTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.data_byte      (data_byte),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.underrun       (underrun),
		.fill_level     (fill_level),
		.finished       (finished),
		.underrun_total (underrun_total)
	);

endmodule
